// ===== rtl/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg: shared constants and types for the lidar return decoder
// Angle constants, fixed-point trig constants, register indexes, item fields.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int TRIG_BITS_DEF = 16;

    // angles in 1/200 degree, azimuths in 1/100 degree
    localparam int TURN    = 72000;
    localparam int QUARTER = 18000;
    localparam int EIGHTH  = 9000;
    localparam int AZ_WRAP = 36000;
    localparam int VSTEP   = 200;
    localparam int VOFFS   = 15;

    // x = t*pi/36000 in Q30, split as t*PI_INT + t*PI_FRAC/PI_DEN
    localparam int PI_INT      = 93701;
    localparam int PI_FRAC     = 23426;
    localparam int PI_DEN      = 36000;
    localparam int PI_RECIP_SH = 28;
    localparam int PI_RECIP    = (1 << PI_RECIP_SH) / PI_DEN;

    localparam int STEPS     = 8;
    localparam int RECIP_SH  = 31;
    // input reg, 3 angle stages, x^2 stage, 3 per series step, output reg
    localparam int TRIG_LAT  = 5 + 3 * STEPS + 1;

    localparam int COORD_MAX = 131071;
    localparam int COORD_MIN = -131072;

    typedef enum logic [2:0] {
        REG_MIN_DIST   = 3'd0,
        REG_MIN_HEIGHT = 3'd1,
        REG_KEEP_FIRST = 3'd2,
        REG_OFFSET_X   = 3'd3,
        REG_OFFSET_Y   = 3'd4,
        REG_OFFSET_Z   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [15:0] range_raw;
        logic        firing;
        logic [7:0]  intensity;
        logic [3:0]  channel;
    } item_meta_t;

    // series divisor (n+1)(n+2) for step k; odd lane starts at n=1
    function automatic int series_div(input bit odd, input int k);
        int n;
        n = 2 * k + (odd ? 1 : 0);
        return (n + 1) * (n + 2);
    endfunction

endpackage

// ===== rtl/lrc_trig.sv =====
// ----------------------------------------------------------------------------
// lrc_trig: pipelined sine/cosine of an angle in 1/200 degree
// Octant reduction, Q30 Taylor series (first term plus 8 steps, one term per 3 stages),
// rounding to TRIG_BITS-1 fraction bits, sign from quadrant.
// ----------------------------------------------------------------------------
module lrc_trig import lrc_pkg::*; #(
    parameter int TRIG_BITS = TRIG_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [16:0]          angle,
    output logic [TRIG_BITS-2:0] sin_mag,
    output logic                 sin_neg,
    output logic [TRIG_BITS-2:0] cos_mag,
    output logic                 cos_neg
);
    localparam int F = TRIG_BITS - 1;

    function automatic logic [F-1:0] to_frac(input logic [31:0] q30);
        logic [32:0] t;
        logic [32:0] v;
        t = {1'b0, q30} + (33'd1 << (29 - F));
        v = t >> (30 - F);
        if (v > 33'((1 << F) - 1)) return F'((1 << F) - 1);
        return v[F-1:0];
    endfunction

    // quadrant / octant reduction
    logic [1:0]  quad;
    logic [16:0] rem;
    logic [13:0] t_in;

    always_comb begin
        priority if (angle >= 17'(3 * QUARTER)) begin
            quad = 2'd3;
            rem  = angle - 17'(3 * QUARTER);
        end else if (angle >= 17'(2 * QUARTER)) begin
            quad = 2'd2;
            rem  = angle - 17'(2 * QUARTER);
        end else if (angle >= 17'(QUARTER)) begin
            quad = 2'd1;
            rem  = angle - 17'(QUARTER);
        end else begin
            quad = 2'd0;
            rem  = angle;
        end
        t_in = (rem > 17'(EIGHTH)) ? 14'(17'(QUARTER) - rem) : rem[13:0];
    end

    logic [1:0]  s0_quad_reg;
    logic        s0_big_reg;
    logic [13:0] s0_t_reg;
    logic [1:0]  s1_quad_reg, s2_quad_reg, s3_quad_reg;
    logic        s1_big_reg, s2_big_reg, s3_big_reg;
    logic [29:0] s1_p1_reg, s2_p1_reg;
    logic [27:0] s1_p2_reg, s2_p2_reg;
    logic [12:0] s2_q_reg;
    logic [29:0] s3_x_reg;

    logic [40:0] pi_prod;
    logic [27:0] pi_rem;
    assign pi_prod = 41'(s1_p2_reg) * 41'(PI_RECIP);
    assign pi_rem  = s2_p2_reg - 28'(28'(s2_q_reg) * 28'(PI_DEN));

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_quad_reg <= quad;
            s0_big_reg  <= (rem > 17'(EIGHTH));
            s0_t_reg    <= t_in;
            s1_quad_reg <= s0_quad_reg;
            s1_big_reg  <= s0_big_reg;
            s1_p1_reg   <= 30'(31'(s0_t_reg) * 31'(PI_INT));
            s1_p2_reg   <= 28'(s0_t_reg) * 28'(PI_FRAC);
            s2_quad_reg <= s1_quad_reg;
            s2_big_reg  <= s1_big_reg;
            s2_p1_reg   <= s1_p1_reg;
            s2_p2_reg   <= s1_p2_reg;
            s2_q_reg    <= pi_prod[PI_RECIP_SH +: 13];
            s3_quad_reg <= s2_quad_reg;
            s3_big_reg  <= s2_big_reg;
            s3_x_reg    <= s2_p1_reg + 30'(s2_q_reg)
                           + 30'(pi_rem >= 28'(PI_DEN));
        end
    end

    // series state: index k feeds step k, index STEPS is the result
    logic [29:0] x2_reg    [0:STEPS];
    logic [30:0] term_o_reg[0:STEPS];
    logic [30:0] term_e_reg[0:STEPS];
    logic [31:0] sum_o_reg [0:STEPS];
    logic [31:0] sum_e_reg [0:STEPS];
    logic [1:0]  quad_reg  [0:STEPS];
    logic        big_reg   [0:STEPS];

    logic [59:0] x_sq;
    assign x_sq = 60'(s3_x_reg) * 60'(s3_x_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg[0]     <= x_sq[59:30];
            term_o_reg[0] <= {1'b0, s3_x_reg};
            term_e_reg[0] <= 31'd1 << 30;
            sum_o_reg[0]  <= {2'b00, s3_x_reg};
            sum_e_reg[0]  <= 32'd1 << 30;
            quad_reg[0]   <= s3_quad_reg;
            big_reg[0]    <= s3_big_reg;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int  DIV_O   = series_div(1'b1, k);
        localparam int  DIV_E   = series_div(1'b0, k);
        localparam logic [30:0] RCP_O = 31'((64'd1 << RECIP_SH) / DIV_O);
        localparam logic [30:0] RCP_E = 31'((64'd1 << RECIP_SH) / DIV_E);
        localparam bit  SUB     = ((k % 2) == 0);

        logic [30:0] a_v_o_reg, a_v_e_reg;
        logic [31:0] a_sum_o_reg, a_sum_e_reg, b_sum_o_reg, b_sum_e_reg;
        logic [29:0] a_x2_reg, b_x2_reg;
        logic [1:0]  a_quad_reg, b_quad_reg;
        logic        a_big_reg, b_big_reg;
        logic [30:0] b_v_o_reg, b_v_e_reg, b_q_o_reg, b_q_e_reg;

        logic [60:0] mul_o, mul_e;
        logic [61:0] rcp_o, rcp_e;
        logic [39:0] diff_o, diff_e;
        logic [30:0] nt_o, nt_e;

        assign mul_o  = 61'(term_o_reg[k]) * 61'(x2_reg[k]);
        assign mul_e  = 61'(term_e_reg[k]) * 61'(x2_reg[k]);
        assign rcp_o  = 62'(a_v_o_reg) * 62'(RCP_O);
        assign rcp_e  = 62'(a_v_e_reg) * 62'(RCP_E);
        assign diff_o = 40'(b_v_o_reg) - 40'(b_q_o_reg) * 40'(DIV_O);
        assign diff_e = 40'(b_v_e_reg) - 40'(b_q_e_reg) * 40'(DIV_E);
        assign nt_o   = b_q_o_reg + 31'(diff_o[9:0] >= 10'(DIV_O));
        assign nt_e   = b_q_e_reg + 31'(diff_e[9:0] >= 10'(DIV_E));

        always_ff @(posedge aclk) begin
            if (en) begin
                a_v_o_reg   <= mul_o[60:30];
                a_v_e_reg   <= mul_e[60:30];
                a_sum_o_reg <= sum_o_reg[k];
                a_sum_e_reg <= sum_e_reg[k];
                a_x2_reg    <= x2_reg[k];
                a_quad_reg  <= quad_reg[k];
                a_big_reg   <= big_reg[k];

                b_v_o_reg   <= a_v_o_reg;
                b_v_e_reg   <= a_v_e_reg;
                b_q_o_reg   <= rcp_o[61:31];
                b_q_e_reg   <= rcp_e[61:31];
                b_sum_o_reg <= a_sum_o_reg;
                b_sum_e_reg <= a_sum_e_reg;
                b_x2_reg    <= a_x2_reg;
                b_quad_reg  <= a_quad_reg;
                b_big_reg   <= a_big_reg;

                term_o_reg[k+1] <= nt_o;
                term_e_reg[k+1] <= nt_e;
                sum_o_reg[k+1]  <= SUB ? b_sum_o_reg - 32'(nt_o) : b_sum_o_reg + 32'(nt_o);
                sum_e_reg[k+1]  <= SUB ? b_sum_e_reg - 32'(nt_e) : b_sum_e_reg + 32'(nt_e);
                x2_reg[k+1]     <= b_x2_reg;
                quad_reg[k+1]   <= b_quad_reg;
                big_reg[k+1]    <= b_big_reg;
            end
        end
    end

    // octant swap and quadrant signs
    logic [F-1:0] bs, bc;
    logic [F-1:0] s_next, c_next;
    logic         sn_next, cn_next;

    always_comb begin
        if (big_reg[STEPS]) begin
            bs = to_frac(sum_e_reg[STEPS]);
            bc = to_frac(sum_o_reg[STEPS]);
        end else begin
            bs = to_frac(sum_o_reg[STEPS]);
            bc = to_frac(sum_e_reg[STEPS]);
        end
        unique case (quad_reg[STEPS])
            2'd0: begin s_next = bs; sn_next = 1'b0; c_next = bc; cn_next = 1'b0; end
            2'd1: begin s_next = bc; sn_next = 1'b0; c_next = bs; cn_next = 1'b1; end
            2'd2: begin s_next = bs; sn_next = 1'b1; c_next = bc; cn_next = 1'b1; end
            default: begin s_next = bc; sn_next = 1'b1; c_next = bs; cn_next = 1'b0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_mag <= s_next;
            sin_neg <= sn_next;
            cos_mag <= c_next;
            cos_neg <= cn_next;
        end
    end

endmodule

// ===== rtl/lidar_return_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// lidar_return_to_cartesian: 16-channel lidar return to Cartesian point
// Pipelined spherical-to-Cartesian decode with offsets, saturation, filters.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel s_*: one lidar return per item (azimuths, firing half,
//    channel, raw distance in 2 mm units, intensity). valid/ready.
//  - Output channel m_*: one point per kept return (x, y, z in mm,
//    saturated to 18 bits signed, plus intensity and channel). Returns that
//    fail the firing, distance or height tests produce no item.
//  - Config port cfg_*: plain write, index per register list, taken any
//    cycle; write only while the pipe is empty.
//  - Pipeline: 1 angle stage, TRIG_LAT trig stages and 4 scale/filter
//    stages lie between input accept and output valid. The trig series,
//    one Taylor term per three stages, sets the depth.
//  - Throughput: one item per cycle while the output is not stalled.
//  - Stall: the whole pipe advances together; while a point sits in the
//    output register and m_ready is low, s_ready is low and nothing moves.
//    Bubbles and dropped points never block.
//  - Reset: all valid bits clear, config registers return to their reset values.
// ----------------------------------------------------------------------------
module lidar_return_to_cartesian import lrc_pkg::*; #(
    parameter int TRIG_BITS = TRIG_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [17:0]        cfg_wdata,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_azimuth,
    input  logic [15:0]        s_next_azimuth,
    input  logic               s_has_next,
    input  logic               s_firing,
    input  logic [3:0]         s_channel,
    input  logic [15:0]        s_distance_raw,
    input  logic [7:0]         s_intensity,
    // output items
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_x_mm,
    output logic signed [17:0] m_y_mm,
    output logic signed [17:0] m_z_mm,
    output logic [7:0]         m_point_intensity,
    output logic [3:0]         m_point_channel
);
    localparam int F  = TRIG_BITS - 1;
    localparam int DW = 17;          // range in mm
    localparam int AW = DW + F;      // range times one trig factor
    localparam int LO = AW / 2;
    localparam int HI = AW - LO;
    localparam int XW = AW + F;      // range times two trig factors

    // ---------------- configuration registers ----------------
    logic [15:0]        min_dist_reg;
    logic signed [17:0] min_height_reg;
    logic               keep_first_reg;
    logic signed [13:0] off_x_reg, off_y_reg, off_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dist_reg   <= 16'd100;
            min_height_reg <= -18'sd1800;
            keep_first_reg <= 1'b0;
            off_x_reg      <= '0;
            off_y_reg      <= '0;
            off_z_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MIN_DIST:   min_dist_reg   <= cfg_wdata[15:0];
                REG_MIN_HEIGHT: min_height_reg <= $signed(cfg_wdata);
                REG_KEEP_FIRST: keep_first_reg <= cfg_wdata[0];
                REG_OFFSET_X:   off_x_reg      <= $signed(cfg_wdata[13:0]);
                REG_OFFSET_Y:   off_y_reg      <= $signed(cfg_wdata[13:0]);
                REG_OFFSET_Z:   off_z_reg      <= $signed(cfg_wdata[13:0]);
                default: ;
            endcase
        end
    end

    // one global advance: the pipe moves unless a point waits at the output
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------- stage 0: horizontal and vertical angles ----------------
    logic [15:0] az, naz;
    logic [16:0] h_next, va_next, wrap_sum;

    always_comb begin
        az  = (s_azimuth >= 16'(AZ_WRAP)) ? s_azimuth - 16'(AZ_WRAP) : s_azimuth;
        naz = (s_next_azimuth >= 16'(AZ_WRAP)) ? s_next_azimuth - 16'(AZ_WRAP)
                                               : s_next_azimuth;
        wrap_sum = 17'(az) + 17'(naz) + 17'(AZ_WRAP);
        // second firing sits at the midpoint; equal azimuths do not wrap
        priority if (!s_firing || !s_has_next || az == naz) begin
            h_next = {az, 1'b0};
        end else if (az < naz) begin
            h_next = 17'(az) + 17'(naz);
        end else if (wrap_sum >= 17'(TURN)) begin
            h_next = wrap_sum - 17'(TURN);
        end else begin
            h_next = wrap_sum;
        end
        // odd channel: +ch deg; even channel: ch-15 deg, wrapped to positive
        if (s_channel[0]) begin
            va_next = 17'(s_channel) * 17'(VSTEP);
        end else begin
            va_next = 17'(TURN) - 17'(4'(VOFFS) - s_channel) * 17'(VSTEP);
        end
    end

    logic        t0_valid_reg;
    logic [16:0] h_reg, va_reg;
    item_meta_t  t0_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_valid_reg <= 1'b0;
        end else if (en) begin
            t0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg       <= h_next;
            va_reg      <= va_next;
            t0_meta_reg <= '{range_raw: s_distance_raw, firing: s_firing,
                             intensity: s_intensity, channel: s_channel};
        end
    end

    // ---------------- trig pipes ----------------
    logic [F-1:0] sh_mag, ch_mag, sv_mag, cv_mag;
    logic         sh_neg, ch_neg, sv_neg, cv_neg;

    lrc_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_h (
        .aclk    (aclk),
        .en      (en),
        .angle   (h_reg),
        .sin_mag (sh_mag),
        .sin_neg (sh_neg),
        .cos_mag (ch_mag),
        .cos_neg (ch_neg)
    );

    lrc_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_v (
        .aclk    (aclk),
        .en      (en),
        .angle   (va_reg),
        .sin_mag (sv_mag),
        .sin_neg (sv_neg),
        .cos_mag (cv_mag),
        .cos_neg (cv_neg)
    );

    // item data rides alongside the trig pipes
    logic       dl_valid_reg [0:TRIG_LAT-1];
    item_meta_t dl_meta_reg  [0:TRIG_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TRIG_LAT; i++) dl_valid_reg[i] <= 1'b0;
        end else if (en) begin
            dl_valid_reg[0] <= t0_valid_reg;
            for (int i = 1; i < TRIG_LAT; i++) dl_valid_reg[i] <= dl_valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_meta_reg[0] <= t0_meta_reg;
            for (int i = 1; i < TRIG_LAT; i++) dl_meta_reg[i] <= dl_meta_reg[i-1];
        end
    end

    // ---------------- P1: range times vertical trig ----------------
    logic          p1_valid_reg, p2_valid_reg, p3_valid_reg;
    item_meta_t    p1_meta_reg, p2_meta_reg, p3_meta_reg;
    logic [AW-1:0] p1_dc_reg, p1_dz_reg;
    logic [F-1:0]  p1_sh_reg, p1_ch_reg;
    logic          p1_xneg_reg, p1_yneg_reg, p1_zneg_reg;
    logic [DW-1:0] d_mm;

    assign d_mm = {dl_meta_reg[TRIG_LAT-1].range_raw, 1'b0};

    // ---------------- P2: partial products, z rounding ----------------
    logic [HI+F-1:0] p2_xh_reg, p2_yh_reg;
    logic [LO+F-1:0] p2_xl_reg, p2_yl_reg;
    logic [17:0]     p2_zm_reg;
    logic            p2_xneg_reg, p2_yneg_reg, p2_zneg_reg;
    logic [AW:0]     z_round;

    assign z_round = {1'b0, p1_dz_reg} + ((AW+1)'(1) << (F - 1));

    // ---------------- P3: x, y rounding and signs ----------------
    logic signed [18:0] p3_x_reg, p3_y_reg, p3_z_reg;
    logic [XW:0]        x_round, y_round;
    logic [17:0]        x_mag, y_mag;

    assign x_round = ((XW+1)'(p2_xh_reg) << LO) + (XW+1)'(p2_xl_reg)
                   + ((XW+1)'(1) << (2 * F - 1));
    assign y_round = ((XW+1)'(p2_yh_reg) << LO) + (XW+1)'(p2_yl_reg)
                   + ((XW+1)'(1) << (2 * F - 1));
    assign x_mag   = x_round[XW:2*F];
    assign y_mag   = y_round[XW:2*F];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= dl_valid_reg[TRIG_LAT-1];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_meta_reg <= dl_meta_reg[TRIG_LAT-1];
            p1_dc_reg   <= AW'(d_mm) * AW'(cv_mag);
            p1_dz_reg   <= AW'(d_mm) * AW'(sv_mag);
            p1_sh_reg   <= sh_mag;
            p1_ch_reg   <= ch_mag;
            p1_xneg_reg <= cv_neg ^ sh_neg;
            p1_yneg_reg <= cv_neg ^ ch_neg;
            p1_zneg_reg <= sv_neg;

            p2_meta_reg <= p1_meta_reg;
            p2_xh_reg   <= (HI+F)'(p1_dc_reg[AW-1:LO]) * (HI+F)'(p1_sh_reg);
            p2_yh_reg   <= (HI+F)'(p1_dc_reg[AW-1:LO]) * (HI+F)'(p1_ch_reg);
            p2_xl_reg   <= (LO+F)'(p1_dc_reg[LO-1:0]) * (LO+F)'(p1_sh_reg);
            p2_yl_reg   <= (LO+F)'(p1_dc_reg[LO-1:0]) * (LO+F)'(p1_ch_reg);
            p2_zm_reg   <= z_round[AW:F];
            p2_xneg_reg <= p1_xneg_reg;
            p2_yneg_reg <= p1_yneg_reg;
            p2_zneg_reg <= p1_zneg_reg;

            p3_meta_reg <= p2_meta_reg;
            p3_x_reg    <= p2_xneg_reg ? -$signed({1'b0, x_mag}) : $signed({1'b0, x_mag});
            p3_y_reg    <= p2_yneg_reg ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
            p3_z_reg    <= p2_zneg_reg ? -$signed({1'b0, p2_zm_reg})
                                       : $signed({1'b0, p2_zm_reg});
        end
    end

    // ---------------- P4: offsets, saturation, filters ----------------
    function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
        if (v > 20'(COORD_MAX)) return 18'(COORD_MAX);
        if (v < 20'(COORD_MIN)) return 18'(COORD_MIN);
        return v[17:0];
    endfunction

    logic signed [17:0] x_sat, y_sat, z_sat;
    logic               keep;

    assign x_sat = sat18(20'(p3_x_reg) + 20'(off_x_reg));
    assign y_sat = sat18(20'(p3_y_reg) + 20'(off_y_reg));
    assign z_sat = sat18(20'(p3_z_reg) + 20'(off_z_reg));
    assign keep  = p3_valid_reg
                && (p3_meta_reg.firing || keep_first_reg)
                && (p3_meta_reg.range_raw > min_dist_reg)
                && (z_sat > min_height_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_x_mm            <= x_sat;
            m_y_mm            <= y_sat;
            m_z_mm            <= z_sat;
            m_point_intensity <= p3_meta_reg.intensity;
            m_point_channel   <= p3_meta_reg.channel;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/lrc_props.sv =====
// ----------------------------------------------------------------------------
// lrc_props: port-level assertions for the lidar return decoder
// Output hold under stall, ready coupling to the output register, reset.
// ----------------------------------------------------------------------------
module lrc_props (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [17:0] m_x_mm,
    input logic signed [17:0] m_y_mm,
    input logic signed [17:0] m_z_mm
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_x_mm) && $stable(m_y_mm) && $stable(m_z_mm))
        else $error("output item changed while stalled");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked with output free");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while pipe is stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind lidar_return_to_cartesian lrc_props u_props (.*);

// ===== bench/lrc_checker.sv =====
// ----------------------------------------------------------------------------
// lrc_checker: point predictor and scoreboard for the lidar return decoder
// Watches the config port and both item channels, predicts each point from
// its own copy of the registers and compares the points in order.
// ----------------------------------------------------------------------------
module lrc_checker import lrc_pkg::*; #(
    parameter int TRIG_BITS = TRIG_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [17:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [15:0]        s_azimuth,
    input  logic [15:0]        s_next_azimuth,
    input  logic               s_has_next,
    input  logic               s_firing,
    input  logic [3:0]         s_channel,
    input  logic [15:0]        s_distance_raw,
    input  logic [7:0]         s_intensity,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [17:0] m_x_mm,
    input  logic signed [17:0] m_y_mm,
    input  logic signed [17:0] m_z_mm,
    input  logic [7:0]         m_point_intensity,
    input  logic [3:0]         m_point_channel,
    output int                 fail_count,
    output int                 points_pending
);

    localparam int                F      = TRIG_BITS - 1;
    localparam longint unsigned   PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic [7:0]         intensity;
        logic [3:0]         channel;
    } point_t;

    point_t points_due[$];

    logic [15:0]        min_dist;
    logic signed [17:0] min_height;
    logic               keep_first;
    logic signed [13:0] off_x, off_y, off_z;

    function automatic longint unsigned taylor_q30(int unsigned t, bit odd);
        longint unsigned x, x2, term, sum, n;
        x    = (longint'(t) * PI_Q30) / 36000;
        x2   = (x * x) >> 30;
        term = odd ? x : (64'd1 << 30);
        sum  = term;
        n    = odd ? 1 : 0;
        for (int k = 0; k < STEPS; k++) begin
            term = ((term * x2) >> 30) / ((n + 1) * (n + 2));
            n += 2;
            if (k % 2 == 0) sum -= term;
            else            sum += term;
        end
        return sum;
    endfunction

    function automatic longint q30_to_frac(longint unsigned q);
        longint unsigned v;
        v = (q + (64'd1 << (29 - F))) >> (30 - F);
        return (v > (64'd1 << F) - 1) ? (64'd1 << F) - 1 : v;
    endfunction

    // angle in 1/200 degree, 0..TURN-1
    task automatic sin_cos(input int unsigned a, output longint s, output longint c);
        int unsigned q, r;
        longint bs, bc;
        q = (a / QUARTER) % 4;
        r = a % QUARTER;
        if (r <= EIGHTH) begin
            bs = q30_to_frac(taylor_q30(r, 1));
            bc = q30_to_frac(taylor_q30(r, 0));
        end else begin
            bs = q30_to_frac(taylor_q30(QUARTER - r, 0));
            bc = q30_to_frac(taylor_q30(QUARTER - r, 1));
        end
        case (q)
            0: begin s = bs;  c = bc;  end
            1: begin s = bc;  c = -bs; end
            2: begin s = -bs; c = -bc; end
            default: begin s = -bc; c = bs; end
        endcase
    endtask

    // range times one or two trig factors, rounded half away from zero
    function automatic longint range_scale(longint d, longint f1, longint f2, bit two);
        bit neg;
        longint unsigned mag;
        int sh;
        neg = (f1 < 0);
        mag = d * (f1 < 0 ? -f1 : f1);
        sh  = F;
        if (two) begin
            neg ^= (f2 < 0);
            mag *= (f2 < 0 ? -f2 : f2);
            sh  = 2 * F;
        end
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint clamp18(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    always @(posedge aclk) begin
        int unsigned az, naz, h, va;
        int     vdeg;
        longint sh_, ch_, sv, cv, x, y, z;
        point_t got, want;
        if (!aresetn) begin
            min_dist   <= 16'd100;
            min_height <= -18'sd1800;
            keep_first <= 1'b0;
            off_x <= '0; off_y <= '0; off_z <= '0;
            points_due.delete();
            points_pending <= 0;
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MIN_DIST:   min_dist   <= cfg_wdata[15:0];
                    REG_MIN_HEIGHT: min_height <= cfg_wdata;
                    REG_KEEP_FIRST: keep_first <= cfg_wdata[0];
                    REG_OFFSET_X:   off_x      <= cfg_wdata[13:0];
                    REG_OFFSET_Y:   off_y      <= cfg_wdata[13:0];
                    REG_OFFSET_Z:   off_z      <= cfg_wdata[13:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                az  = s_azimuth % AZ_WRAP;
                naz = s_next_azimuth % AZ_WRAP;
                if (!s_firing || !s_has_next || az == naz) h = 2 * az;
                else if (az < naz) h = az + naz;
                else h = (az + naz + AZ_WRAP) % TURN;
                vdeg = s_channel[0] ? int'(s_channel) : int'(s_channel) - VOFFS;
                va   = vdeg < 0 ? vdeg * VSTEP + TURN : vdeg * VSTEP;
                sin_cos(h, sh_, ch_);
                sin_cos(va, sv, cv);
                z = clamp18(range_scale(2 * s_distance_raw, sv, 0, 0) + off_z);
                y = clamp18(range_scale(2 * s_distance_raw, cv, ch_, 1) + off_y);
                x = clamp18(range_scale(2 * s_distance_raw, cv, sh_, 1) + off_x);
                if ((s_firing || keep_first) && s_distance_raw > min_dist
                        && z > longint'(min_height)) begin
                    want.x = 18'(x); want.y = 18'(y); want.z = 18'(z);
                    want.intensity = s_intensity;
                    want.channel   = s_channel;
                    points_due.insert(points_due.size(), want);
                end
            end
            if (m_valid && m_ready) begin
                got = {m_x_mm, m_y_mm, m_z_mm, m_point_intensity, m_point_channel};
                if (points_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected point x=%0d y=%0d z=%0d", m_x_mm, m_y_mm, m_z_mm);
                end else begin
                    want = points_due.pop_front();
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("point mismatch: exp x=%0d y=%0d z=%0d i=%0d ch=%0d, got x=%0d y=%0d z=%0d i=%0d ch=%0d",
                                want.x, want.y, want.z, want.intensity, want.channel,
                                got.x, got.y, got.z, got.intensity, got.channel);
                    end
                end
            end
            points_pending <= points_due.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the lidar return decoder
// Drives directed and random returns through several register settings with
// bursty input and stalling output; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import lrc_pkg::*;

    // index past the register list, must be ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;
    // pipe depth plus margin, for dropped items still in flight
    localparam int DRAIN_CYCLES = TRIG_LAT + 5 + 20;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [15:0] az;
        logic [15:0] naz;
        logic        has_next;
        logic        firing;
        logic [3:0]  channel;
        logic [15:0] range_raw;
        logic [7:0]  intensity;
    } lidar_return_t;

    logic aclk = 0, aresetn = 0;
    logic cfg_wr_en = 0;
    logic [2:0] cfg_addr = '0;
    logic [17:0] cfg_wdata = '0;
    logic s_valid = 0, s_ready;
    logic [15:0] s_azimuth = '0, s_next_azimuth = '0, s_distance_raw = '0;
    logic s_has_next = 0, s_firing = 0;
    logic [3:0] s_channel = '0;
    logic [7:0] s_intensity = '0;
    logic m_valid, m_ready = 0;
    logic signed [17:0] m_x_mm, m_y_mm, m_z_mm;
    logic [7:0] m_point_intensity;
    logic [3:0] m_point_channel;
    int fail_count, points_pending;
    int cycles = 0;
    bit hold_req = 0;   // set by stimulus, starts the long receiver stall
    bit hold_on = 0;    // long stall in progress

    initial begin
        forever #5 aclk = ~aclk;
    end

    lidar_return_to_cartesian u_dut (.*);

    lrc_checker u_chk (.*);

    // timeout
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // long stall, counted here, so the pipe backs up into s_ready
    initial begin
        wait (hold_req);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    // receiver: stall mode redrawn at random; held low during the long stall
    always @(posedge aclk) begin
        static int mode = 0;
        if (cycles % 64 == 0) mode = $urandom_range(0, 3);
        if (hold_on) begin
            m_ready <= 1'b0;
        end else begin
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // one write, then the strobe drops and the port idles before the task returns
    task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one return and hold it until taken; valid stays up afterwards
    task automatic offer_return(input lidar_return_t r);
        s_valid        <= 1'b1;
        s_azimuth      <= r.az;
        s_next_azimuth <= r.naz;
        s_has_next     <= r.has_next;
        s_firing       <= r.firing;
        s_channel      <= r.channel;
        s_distance_raw <= r.range_raw;
        s_intensity    <= r.intensity;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // stop offering, let every point out, then let dropped items clear the pipe
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (points_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic lidar_return_t mk(int az, int naz, bit hn, bit fi, int ch, int d, int in);
        lidar_return_t r;
        r.az = 16'(az); r.naz = 16'(naz); r.has_next = hn; r.firing = fi;
        r.channel = 4'(ch); r.range_raw = 16'(d); r.intensity = 8'(in);
        return r;
    endfunction

    // mostly in-range scans with plausible ranges, some raw noise
    function automatic lidar_return_t random_return();
        lidar_return_t r;
        int sel;
        sel = $urandom_range(0, 9);
        r.az = 16'((sel == 0) ? $urandom_range(36000, 65535) : $urandom_range(0, 35999));
        case ($urandom_range(0, 3))
            0: r.naz = 16'($urandom_range(0, 65535));
            1: r.naz = r.az;
            default: r.naz = 16'((r.az % AZ_WRAP + $urandom_range(1, 60)) % AZ_WRAP);
        endcase
        r.has_next  = ($urandom_range(0, 7) != 0);
        r.firing    = 1'($urandom_range(0, 1));
        r.channel   = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0, 1: r.range_raw = 16'($urandom_range(0, 65535));
            2:    r.range_raw = 16'($urandom_range(0, 200));
            default: r.range_raw = 16'($urandom_range(100, 20000));
        endcase
        r.intensity = 8'($urandom_range(0, 255));
        return r;
    endfunction

    // bursts of random length separated by random gaps
    task automatic random_items(input int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && n > 0) begin
                offer_return(random_return());
                burst--; n--;
            end
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: first firings, near points and low points dropped
        random_items(150);
        wait_drained();

        // open filters: keep first firings and every point with a nonzero range
        write_reg(REG_MIN_DIST, 18'd0);
        write_reg(REG_MIN_HEIGHT, 18'h20000);
        write_reg(REG_KEEP_FIRST, 18'd1);
        write_reg(REG_UNUSED, 18'h3FFFF);

        // directed: field extremes, wrap cases, quadrant edges, all channels ends
        offer_return(mk(0, 0, 1, 1, 0, 0, 0));
        offer_return(mk(35999, 35999, 1, 1, 15, 65535, 255));
        offer_return(mk(65535, 65535, 1, 1, 1, 65535, 255));
        offer_return(mk(100, 200, 1, 1, 14, 5000, 17));
        offer_return(mk(35990, 10, 1, 1, 7, 5000, 18));
        offer_return(mk(20000, 20000, 1, 1, 8, 5000, 19));
        offer_return(mk(12345, 5000, 0, 1, 3, 5000, 20));
        offer_return(mk(12345, 5000, 1, 0, 3, 5000, 21));
        offer_return(mk(9000, 9000, 0, 0, 15, 40000, 22));
        offer_return(mk(4500, 0, 0, 0, 15, 40000, 23));
        offer_return(mk(18000, 0, 0, 0, 1, 40000, 24));
        offer_return(mk(27000, 0, 0, 0, 0, 40000, 25));
        offer_return(mk(2250, 0, 0, 0, 2, 65535, 26));
        offer_return(mk(36000, 1, 1, 1, 9, 1, 27));
        offer_return(mk(0, 35999, 1, 1, 13, 2, 28));
        offer_return(mk(4500, 13500, 1, 1, 5, 30000, 29));
        random_items(200);
        wait_drained();

        // extreme positive offsets
        write_reg(REG_OFFSET_X, 18'd8191);
        write_reg(REG_OFFSET_Y, 18'd8191);
        write_reg(REG_OFFSET_Z, 18'd8191);
        random_items(150);
        wait_drained();

        // extreme negative offsets, drop first firings, stricter height
        write_reg(REG_OFFSET_X, 18'h3E000);
        write_reg(REG_OFFSET_Y, 18'h3E000);
        write_reg(REG_OFFSET_Z, 18'h3E000);
        write_reg(REG_KEEP_FIRST, 18'd0);
        write_reg(REG_MIN_HEIGHT, 18'h3F000);
        random_items(150);
        // long output stall while the sender keeps pushing
        hold_req = 1;
        for (int i = 0; i < 120; i++) offer_return(random_return());
        wait_drained();

        // thresholds at their top: no points can pass
        write_reg(REG_MIN_DIST, 18'd65535);
        write_reg(REG_MIN_HEIGHT, 18'd131071);
        random_items(60);
        wait_drained();

        // mid settings, mixed offsets
        write_reg(REG_MIN_DIST, 18'd500);
        write_reg(REG_MIN_HEIGHT, 18'h3FC18);
        write_reg(REG_KEEP_FIRST, 18'd1);
        write_reg(REG_OFFSET_X, 18'd1234);
        write_reg(REG_OFFSET_Y, 18'h3FF00);
        write_reg(REG_OFFSET_Z, 18'd77);
        random_items(250);
        wait_drained();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lrc_pkg.sv
rtl/lrc_trig.sv
rtl/lidar_return_to_cartesian.sv
rtl/lrc_props.sv
bench/lrc_checker.sv
bench/tb_top.sv
